// ----- hw/rtl/cbd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the chunked body deframer: phase encoding, result type,
// byte constants and the hex digit decoder. Depends on nothing.
package cbd_pkg;

	localparam int MAX_SIZE_DIGITS_DEF = 7;
	localparam int REMAIN_W = 28;
	localparam logic [7:0] CR_BYTE = 8'h0D;

	typedef enum logic [3:0] {
		PH_SIZE    = 4'd0,
		PH_SKIP_LF = 4'd1,
		PH_DATA    = 4'd2,
		PH_TRAIL_A = 4'd3,
		PH_TRAIL_B = 4'd4,
		PH_END_A   = 4'd5,
		PH_END_B   = 4'd6,
		PH_DONE    = 4'd7,
		PH_ERROR   = 4'd8
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       body_done;
		logic       framing_error;
	} cbd_result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] b);
		hex_digit_t d;
		d.ok = 1'b1;
		d.value = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			d.value = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			d.value = 4'(b - 8'h61 + 8'd10);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			d.value = 4'(b - 8'h41 + 8'd10);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

// ----- hw/rtl/cbd_core.sv -----
`timescale 1ns / 1ps
// Framing state machine and result register of the chunked body deframer.
// Depends on cbd_pkg.
module cbd_core #(
	parameter int MAX_SIZE_DIGITS = cbd_pkg::MAX_SIZE_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          byte_s1,
	output cbd_pkg::cbd_result_t result_q
);
	import cbd_pkg::*;

	localparam int DIGIT_W = $clog2(MAX_SIZE_DIGITS + 1);

	phase_t                phase_q, phase_d;
	logic [REMAIN_W-1:0]   remain_q, remain_d;
	logic [DIGIT_W-1:0]    digits_q, digits_d;
	cbd_result_t           result_d;
	hex_digit_t            hex;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIZE;
			remain_q <= '0;
			digits_q <= '0;
			result_q <= '0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			digits_q <= digits_d;
			result_q <= result_d;
		end
	end

	always_comb begin
		hex = hex_decode(byte_s1);
		phase_d = phase_q;
		remain_d = remain_q;
		digits_d = digits_q;
		result_d = '0;
		case (phase_q)
			PH_SIZE: begin
				if (byte_s1 == CR_BYTE) begin
					phase_d = PH_SKIP_LF;
				end else if (digits_q >= DIGIT_W'(MAX_SIZE_DIGITS)) begin
					phase_d = PH_ERROR;
				end else if (!hex.ok) begin
					phase_d = PH_ERROR;
				end else begin
					remain_d = {remain_q[REMAIN_W-5:0], hex.value};
					digits_d = digits_q + DIGIT_W'(1);
				end
			end
			PH_SKIP_LF: begin
				digits_d = '0;
				phase_d = (remain_q == '0) ? PH_END_A : PH_DATA;
			end
			PH_DATA: begin
				result_d.payload_valid = 1'b1;
				result_d.payload_byte = byte_s1;
				remain_d = remain_q - REMAIN_W'(1);
				if (remain_q == REMAIN_W'(1)) begin
					phase_d = PH_TRAIL_A;
				end
			end
			PH_TRAIL_A: phase_d = PH_TRAIL_B;
			PH_TRAIL_B: begin
				phase_d = PH_SIZE;
				remain_d = '0;
				digits_d = '0;
			end
			PH_END_A: phase_d = PH_END_B;
			PH_END_B: phase_d = PH_DONE;
			PH_DONE:  phase_d = PH_DONE;
			PH_ERROR: phase_d = PH_ERROR;
			default:  phase_d = PH_ERROR;
		endcase
		result_d.body_done = (phase_d == PH_DONE);
		result_d.framing_error = (phase_d == PH_ERROR);
	end

endmodule

// ----- hw/rtl/chunked_body_deframer_top.sv -----
`timescale 1ns / 1ps
// Pipeline: an accepted item waits in the input register, which feeds the framing
// state machine; its result register offers the outcome and holds it while the
// output is stalled. Throughput: one item per cycle when the output is not stalled.
// Reset: asynchronous, active low; phase returns to size digits, counts to zero,
// and both pipeline stages are emptied. Depends on cbd_pkg and cbd_core.
module chunked_body_deframer_top #(
	parameter int MAX_SIZE_DIGITS = cbd_pkg::MAX_SIZE_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       payload_valid,
	output logic       body_done,
	output logic       framing_error
);
	import cbd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	logic        out_free;
	logic        s1_free;
	cbd_result_t result_q;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_free  = !valid_s1 || out_free;
	assign in_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	cbd_core #(
		.MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (out_free && valid_s1),
		.byte_s1 (byte_s1),
		.result_q(result_q)
	);

	assign out_valid     = out_valid_q;
	assign payload_byte  = result_q.payload_byte;
	assign payload_valid = result_q.payload_valid;
	assign body_done     = result_q.body_done;
	assign framing_error = result_q.framing_error;

endmodule

// ----- hw/rtl/cbd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the chunked body deframer and the bind that attaches
// them to chunked_body_deframer_top. Depends on nothing else.
module cbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] payload_byte,
	input logic       payload_valid,
	input logic       body_done,
	input logic       framing_error
);
	logic err_seen_q;
	logic done_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q  <= 1'b0;
			done_seen_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			err_seen_q  <= err_seen_q || framing_error;
			done_seen_q <= done_seen_q || body_done;
		end
	end

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && err_seen_q |-> framing_error)
		else $error("framing error did not persist");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_seen_q |-> body_done)
		else $error("body done did not persist");

	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(body_done && framing_error)
			&& !(payload_valid && (body_done || framing_error)))
		else $error("payload, done and error flags conflict");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
			&& $stable(payload_valid))
		else $error("stalled item changed");

endmodule

bind chunked_body_deframer_top cbd_checker u_cbd_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for chunked_body_deframer_top: builds a chunked body
// from directed and random chunks, predicts every result per accepted item and checks it.
// Depends on cbd_pkg and the RTL of chunked_body_deframer_top.
module tb;
	import cbd_pkg::*;

	localparam int SIZE_DIGITS = MAX_SIZE_DIGITS_DEF;
	localparam int LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1150;
	localparam logic [7:0] LF_BYTE = 8'h0A;

	typedef enum int {END_EMPTY, END_ZERO, END_BAD_DIGIT, END_LONG} ending_t;

	typedef struct {
		logic [7:0] b;
		bit         drain;
	} feed_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       body_done;
	logic       framing_error;

	feed_t       feed_q[$];
	cbd_result_t expected_q[$];
	bit          mark_drain;
	int unsigned total_items;
	int unsigned accepted_cnt = 0;
	int unsigned received_cnt = 0;
	int unsigned cycles = 0;
	int unsigned failures = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;

	phase_t                track_phase = PH_SIZE;
	logic [REMAIN_W-1:0]   track_left = '0;
	int unsigned           track_digits = 0;

	chunked_body_deframer_top #(
		.MAX_SIZE_DIGITS(SIZE_DIGITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_byte(payload_byte),
		.payload_valid(payload_valid),
		.body_done(body_done),
		.framing_error(framing_error)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic cbd_result_t deframe_byte(input logic [7:0] b);
		cbd_result_t r;
		logic [3:0]  nib;
		logic        bad;
		r = '0;
		case (track_phase)
			PH_SIZE: begin
				if (b == CR_BYTE) begin
					track_phase = PH_SKIP_LF;
				end else if (track_digits >= SIZE_DIGITS) begin
					track_phase = PH_ERROR;
				end else begin
					bad = 1'b0;
					nib = 4'd0;
					if (b >= "0" && b <= "9") begin
						nib = 4'(b - "0");
					end else if (b >= "a" && b <= "f") begin
						nib = 4'(b - "a" + 10);
					end else if (b >= "A" && b <= "F") begin
						nib = 4'(b - "A" + 10);
					end else begin
						bad = 1'b1;
					end
					if (bad) begin
						track_phase = PH_ERROR;
					end else begin
						track_left = {track_left[REMAIN_W-5:0], nib};
						track_digits++;
					end
				end
			end
			PH_SKIP_LF: begin
				track_digits = 0;
				track_phase = (track_left == '0) ? PH_END_A : PH_DATA;
			end
			PH_DATA: begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				track_left = track_left - 1'b1;
				if (track_left == '0)
					track_phase = PH_TRAIL_A;
			end
			PH_TRAIL_A: track_phase = PH_TRAIL_B;
			PH_TRAIL_B: begin
				track_phase = PH_SIZE;
				track_left = '0;
				track_digits = 0;
			end
			PH_END_A: track_phase = PH_END_B;
			PH_END_B: track_phase = PH_DONE;
			PH_DONE: ;
			default: track_phase = PH_ERROR;
		endcase
		r.body_done = (track_phase == PH_DONE);
		r.framing_error = (track_phase == PH_ERROR);
		return r;
	endfunction

	function automatic int unsigned pick_idle();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_item(input logic [7:0] b);
		feed_t f;
		f.b = b;
		f.drain = mark_drain;
		mark_drain = 1'b0;
		feed_q.push_back(f);
	endtask

	task automatic push_digits(input int unsigned value, input int unsigned nd);
		int         i;
		logic [3:0] n;
		for (i = int'(nd) - 1; i >= 0; i--) begin
			n = 4'(value >> (4 * i));
			if (n < 10)
				push_item(8'h30 + 8'(n));
			else
				push_item(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_q.push_back(deframe_byte(in_byte));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (feed_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (feed_q[0].drain &&
						((in_valid && !in_stall) || accepted_cnt != received_cnt)) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_byte <= feed_q.pop_front().b;
					if ((cycles % 1000) >= 250 && $urandom_range(0, 2) == 0)
						gap_left <= pick_idle();
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		cbd_result_t want;
		cbd_result_t got;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				received_cnt <= received_cnt + 1;
				got = '{payload_byte, payload_valid, body_done, framing_error};
				if (expected_q.size() == 0) begin
					if (failures < 10)
						$display("Result with nothing expected: byte %02h valid %b done %b err %b",
							got.payload_byte, got.payload_valid, got.body_done,
							got.framing_error);
					failures++;
				end else begin
					want = expected_q.pop_front();
					if (got.payload_byte !== want.payload_byte ||
							got.payload_valid !== want.payload_valid ||
							got.body_done !== want.body_done ||
							got.framing_error !== want.framing_error) begin
						if (failures < 10)
							$display({"Mismatch at result %0d: expected byte %02h valid %b ",
								"done %b err %b, got byte %02h valid %b done %b err %b"},
								received_cnt, want.payload_byte, want.payload_valid,
								want.body_done, want.framing_error, got.payload_byte,
								got.payload_valid, got.body_done, got.framing_error);
						failures++;
					end
				end
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				if ((cycles % 700) >= 200 && $urandom_range(0, 3) == 0)
					stall_left <= pick_idle();
			end
		end
	end

	initial begin
		int unsigned size;
		int unsigned nd;
		int unsigned chunk_idx;
		int unsigned i;
		logic [7:0]  b;
		ending_t     ending;

		// Directed chunks: a CR as the skipped byte, payload extremes, a full-width size field.
		mark_drain = 1'b0;
		push_digits(1, 1);
		push_item(CR_BYTE);
		push_item(CR_BYTE);
		push_item(8'h00);
		push_item(CR_BYTE);
		push_item(LF_BYTE);
		push_digits(2, SIZE_DIGITS);
		push_item(CR_BYTE);
		push_item(LF_BYTE);
		push_item(8'hFF);
		push_item(8'h80);
		push_item(8'hFF);
		push_item(8'h00);

		chunk_idx = 0;
		mark_drain = 1'b1;
		while (feed_q.size() < RANDOM_ITEMS) begin
			if (chunk_idx % 25 == 24)
				mark_drain = 1'b1;
			chunk_idx++;
			if ($urandom_range(0, 19) == 0)
				size = $urandom_range(49, 200);
			else
				size = $urandom_range(1, 48);
			nd = 1;
			while ((size >> (4 * nd)) != 0)
				nd++;
			push_digits(size, $urandom_range(nd, SIZE_DIGITS));
			push_item(CR_BYTE);
			push_item(8'($urandom_range(0, 255)));
			for (i = 0; i < size; i++)
				push_item(8'($urandom_range(0, 255)));
			push_item(8'($urandom_range(0, 255)));
			push_item(8'($urandom_range(0, 255)));
		end

		// The body ends in one of four ways; only one can be seen per run.
		mark_drain = 1'b1;
		ending = ending_t'($urandom_range(0, 3));
		case (ending)
			END_EMPTY, END_ZERO: begin
				if (ending == END_ZERO)
					push_digits(0, $urandom_range(1, SIZE_DIGITS));
				push_item(CR_BYTE);
				push_item(8'($urandom_range(0, 255)));
				push_item(8'($urandom_range(0, 255)));
				push_item(8'($urandom_range(0, 255)));
			end
			END_BAD_DIGIT: begin
				nd = $urandom_range(0, SIZE_DIGITS - 1);
				push_digits($urandom, nd);
				do begin
					b = 8'($urandom_range(0, 255));
				end while (b == CR_BYTE || (b >= "0" && b <= "9") ||
					(b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
				push_item(b);
			end
			default: begin
				push_digits($urandom, SIZE_DIGITS);
				do begin
					b = 8'($urandom_range(0, 255));
				end while (b == CR_BYTE);
				push_item(b);
			end
		endcase
		for (i = 0; i < 8; i++)
			push_item(8'($urandom_range(0, 255)));
		total_items = feed_q.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (received_cnt != total_items)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (expected_q.size() != 0) begin
			$display("%0d expected results never arrived", expected_q.size());
			failures += expected_q.size();
		end
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
